>>> rtl/core/jhmp_pkg.sv
// Shared types and constants for the JPEG header marker parser.
// Holds the channel payload structs, the queue entry and the marker classes.
// No dependencies.
package jhmp_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int OFFSET_BITS_MAX = 48;

    localparam logic [2:0] MK_NOPAY = 3'd0;
    localparam logic [2:0] MK_SOF0  = 3'd1;
    localparam logic [2:0] MK_SOS   = 3'd2;
    localparam logic [2:0] MK_FIXED = 3'd3;
    localparam logic [2:0] MK_LEN   = 3'd4;
    localparam logic [2:0] MK_SOFN  = 3'd5;
    localparam logic [2:0] MK_RSVD  = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic        header_ok;
        logic [3:0]  error_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [1:0]  component_count;
        logic [39:0] hres_fixed;
        logic [39:0] vres_fixed;
        logic [31:0] scan_data_offset;
    } out_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
        logic       is_ff;
        logic       is_app0;
        logic [2:0] mclass;
    } jhmp_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } jhmp_qstat_t;

endpackage

>>> rtl/core/jhmp_front.sv
// Front end of the parser: input handshake and marker classification.
// Depends on jhmp_pkg.
module jhmp_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  jhmp_pkg::in_item_t   in_data,
    input  jhmp_pkg::jhmp_qstat_t qstat,
    output logic                 push,
    output jhmp_pkg::jhmp_entry_t entry
);
    import jhmp_pkg::*;

    logic [7:0] c;

    assign c        = in_data.data_byte;
    assign in_ready = !qstat.full;
    assign push     = in_valid && !qstat.full;

    always_comb
    begin
        entry.data_byte     = c;
        entry.end_of_stream = in_data.end_of_stream;
        entry.is_ff         = (c == 8'hff);
        entry.is_app0       = (c == 8'he0);
        priority if (c == 8'h00 || c == 8'h01 || (c >= 8'hd0 && c <= 8'hd9))
            entry.mclass = MK_NOPAY;
        else if (c == 8'hc0)
            entry.mclass = MK_SOF0;
        else if (c == 8'hda)
            entry.mclass = MK_SOS;
        else if (c == 8'hdc || c == 8'hdd)
            entry.mclass = MK_FIXED;
        else if (c == 8'hc4 || c == 8'hdb || c >= 8'he0)
            entry.mclass = MK_LEN;
        else if ((c >= 8'hc1 && c <= 8'hcf) || c == 8'hde || c == 8'hdf)
            entry.mclass = MK_SOFN;
        else
            entry.mclass = MK_RSVD;
    end

endmodule

>>> rtl/core/jhmp_fifo.sv
// Two-entry queue between the classifying front end and the parsing back end.
// Depends on jhmp_pkg.
module jhmp_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  jhmp_pkg::jhmp_entry_t wr_data,
    input  logic                  pop,
    output jhmp_pkg::jhmp_entry_t rd_data,
    output jhmp_pkg::jhmp_qstat_t qstat
);
    import jhmp_pkg::*;

    jhmp_entry_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign rd_data     = mem_reg[rd_ptr_reg];
    assign qstat.empty = (count_reg == 2'd0);
    assign qstat.full  = (count_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/core/jhmp_back.sv
// Back end of the parser: the marker and segment state machine and the result register.
// Depends on jhmp_pkg; takes classified bytes from jhmp_fifo.
module jhmp_back #(
    parameter int OFFSET_BITS = jhmp_pkg::OFFSET_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  strict_version,
    input  jhmp_pkg::jhmp_qstat_t qstat,
    input  jhmp_pkg::jhmp_entry_t entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output jhmp_pkg::out_item_t   out_data
);
    import jhmp_pkg::*;

    localparam logic [3:0] PH_HUNT   = 4'd0;
    localparam logic [3:0] PH_PREFIX = 4'd1;
    localparam logic [3:0] PH_LEN    = 4'd2;
    localparam logic [3:0] PH_SKIP   = 4'd3;
    localparam logic [3:0] PH_SOF    = 4'd4;
    localparam logic [3:0] PH_SOFC   = 4'd5;
    localparam logic [3:0] PH_APPID  = 4'd6;
    localparam logic [3:0] PH_JFIF   = 4'd7;
    localparam logic [3:0] PH_SOS    = 4'd8;
    localparam logic [3:0] PH_SOSC   = 4'd9;
    localparam logic [3:0] PH_SOST   = 4'd10;
    localparam logic [3:0] PH_DONE   = 4'd11;

    localparam logic [3:0] E_NONE   = 4'd0;
    localparam logic [3:0] E_PREC   = 4'd1;
    localparam logic [3:0] E_COMP   = 4'd2;
    localparam logic [3:0] E_SOFN   = 4'd3;
    localparam logic [3:0] E_RSVD   = 4'd4;
    localparam logic [3:0] E_SCANID = 4'd5;
    localparam logic [3:0] E_AC     = 4'd6;
    localparam logic [3:0] E_DC     = 4'd7;
    localparam logic [3:0] E_JFIF   = 4'd8;
    localparam logic [3:0] E_NOSOS  = 4'd9;

    localparam logic [39:0] DPI_DEFAULT = 40'd72 << 16;
    localparam logic [17:0] CM_TO_DPI   = 18'h28a3d;

    logic [3:0]             phase_reg, phase_next;
    logic [15:0]            seg_reg, seg_next;
    logic [3:0]             fpos_reg, fpos_next;
    logic [15:0]            fw_reg, fw_next;
    logic [15:0]            fh_reg, fh_next;
    logic [7:0]             ids_reg [3];
    logic [7:0]             ids_next [3];
    logic [1:0]             fcomp_reg, fcomp_next;
    logic [39:0]            hres_reg, hres_next;
    logic [39:0]            vres_reg, vres_next;
    logic [1:0]             units_reg, units_next;
    logic [3:0]             perr_reg, perr_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic                   app0_reg, app0_next;
    logic [7:0]             hold_reg, hold_next;
    logic [15:0]            xd_reg, xd_next;
    logic [7:0]             thumb_reg, thumb_next;
    logic                   tag_reg, tag_next;
    logic [7:0]             sel_reg [3];
    logic [7:0]             sel_next [3];
    logic [2:0]             selv_reg, selv_next;
    logic [1:0]             slot_reg, slot_next;
    logic                   serr_reg, serr_next;
    logic                   ovalid_reg, ovalid_next;
    out_item_t              odata_reg, odata_next;

    logic                   emit;
    logic                   emit_ok;
    logic [3:0]             emit_code;
    logic [7:0]             b;
    logic [15:0]            word;
    logic [15:0]            len_pay;
    logic [15:0]            seg_dec;
    logic [17:0]            thumb_bytes;
    logic [22:0]            x72;
    logic [22:0]            y72;
    logic [7:0]             tag_byte;
    logic                   ac_bad;
    logic                   dc_bad;
    logic [OFFSET_BITS_MAX-1:0] off_wide;

    assign pop       = !qstat.empty && (!ovalid_reg || out_ready);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign b         = entry.data_byte;
    assign word      = {hold_reg, b};
    assign seg_dec   = seg_reg - 16'd1;
    assign len_pay   = (word >= 16'd2) ? word - 16'd2 : 16'd0;
    assign thumb_bytes = 18'(thumb_reg * b) * 18'd3;
    assign x72       = 23'(xd_reg) * 23'd72;
    assign y72       = 23'(word) * 23'd72;

    always_comb
    begin
        unique case (fpos_reg[1:0])
            2'd0: tag_byte = 8'h4a;
            2'd1: tag_byte = 8'h46;
            2'd2: tag_byte = 8'h49;
            default: tag_byte = 8'h46;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        seg_next   = seg_reg;
        fpos_next  = fpos_reg;
        fw_next    = fw_reg;
        fh_next    = fh_reg;
        ids_next   = ids_reg;
        fcomp_next = fcomp_reg;
        hres_next  = hres_reg;
        vres_next  = vres_reg;
        units_next = units_reg;
        perr_next  = perr_reg;
        offset_next = offset_reg;
        app0_next  = app0_reg;
        hold_next  = hold_reg;
        xd_next    = xd_reg;
        thumb_next = thumb_reg;
        tag_next   = tag_reg;
        sel_next   = sel_reg;
        selv_next  = selv_reg;
        slot_next  = slot_reg;
        serr_next  = serr_reg;
        emit       = 1'b0;
        emit_ok    = 1'b0;
        emit_code  = E_NONE;
        ac_bad     = 1'b0;
        dc_bad     = 1'b0;

        if (phase_reg != PH_DONE)
        begin
            offset_next = offset_reg + 1'b1;
        end

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (entry.is_ff)
                begin
                    phase_next = PH_PREFIX;
                end
            end
            PH_PREFIX:
            begin
                if (!entry.is_ff)
                begin
                    app0_next = entry.is_app0;
                    fpos_next = 4'd0;
                    unique case (entry.mclass)
                        MK_NOPAY: phase_next = PH_HUNT;
                        MK_SOF0:  phase_next = PH_SOF;
                        MK_SOS:   phase_next = PH_SOS;
                        MK_FIXED:
                        begin
                            seg_next   = 16'd4;
                            phase_next = PH_SKIP;
                        end
                        MK_SOFN:
                        begin
                            perr_next  = E_SOFN;
                            phase_next = PH_LEN;
                        end
                        MK_RSVD:
                        begin
                            perr_next  = E_RSVD;
                            phase_next = PH_LEN;
                        end
                        default:  phase_next = PH_LEN;
                    endcase
                end
            end
            PH_LEN:
            begin
                if (fpos_reg == 4'd0)
                begin
                    hold_next = b;
                    fpos_next = 4'd1;
                end
                else
                begin
                    seg_next  = len_pay;
                    fpos_next = 4'd0;
                    if (app0_reg && len_pay > 16'd5)
                    begin
                        tag_next   = 1'b1;
                        phase_next = PH_APPID;
                    end
                    else
                    begin
                        phase_next = (len_pay != 16'd0) ? PH_SKIP : PH_HUNT;
                    end
                end
            end
            PH_SKIP:
            begin
                if (seg_reg != 16'd0)
                begin
                    seg_next = seg_dec;
                end
                if (seg_reg <= 16'd1)
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_SOF:
            begin
                fpos_next = fpos_reg + 4'd1;
                unique case (fpos_reg)
                    4'd2:
                    begin
                        if (b != 8'd8)
                        begin
                            perr_next = E_PREC;
                        end
                    end
                    4'd3, 4'd5: hold_next = b;
                    4'd4: fh_next = word;
                    4'd6: fw_next = word;
                    4'd7:
                    begin
                        fpos_next = 4'd0;
                        if (b == 8'd1 || b == 8'd3)
                        begin
                            fcomp_next = b[1:0];
                            seg_next   = (b == 8'd1) ? 16'd3 : 16'd9;
                            phase_next = PH_SOFC;
                        end
                        else
                        begin
                            fcomp_next = 2'd0;
                            perr_next  = E_COMP;
                            phase_next = PH_HUNT;
                        end
                    end
                    default: ;
                endcase
            end
            PH_SOFC:
            begin
                if (fpos_reg == 4'd0)
                begin
                    ids_next[0] = b;
                end
                if (fpos_reg == 4'd3)
                begin
                    ids_next[1] = b;
                end
                if (fpos_reg == 4'd6)
                begin
                    ids_next[2] = b;
                end
                fpos_next = fpos_reg + 4'd1;
                seg_next  = seg_dec;
                if (seg_dec == 16'd0)
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_APPID:
            begin
                seg_next = seg_dec;
                if (fpos_reg < 4'd4 && b != tag_byte)
                begin
                    tag_next = 1'b0;
                end
                fpos_next = fpos_reg + 4'd1;
                if (fpos_reg == 4'd4)
                begin
                    fpos_next = 4'd0;
                    if (tag_next)
                    begin
                        phase_next = PH_JFIF;
                    end
                    else
                    begin
                        phase_next = (seg_dec != 16'd0) ? PH_SKIP : PH_HUNT;
                    end
                end
            end
            PH_JFIF:
            begin
                seg_next  = seg_dec;
                fpos_next = fpos_reg + 4'd1;
                if (fpos_reg < 4'd8 && seg_dec == 16'd0)
                begin
                    emit = 1'b1;
                end
                unique case (fpos_reg)
                    4'd0, 4'd3, 4'd5: hold_next = b;
                    4'd1:
                    begin
                        if (strict_version ? (word != 16'h100 && word != 16'h101)
                                           : (word < 16'h100))
                        begin
                            emit = 1'b1;
                        end
                    end
                    4'd2: units_next = (b > 8'd2) ? 2'd3 : b[1:0];
                    4'd4: xd_next = word;
                    4'd6:
                    begin
                        unique case (units_reg)
                            2'd0:
                            begin
                                hres_next = 40'({x72, 16'h0});
                                vres_next = 40'({y72, 16'h0});
                            end
                            2'd1:
                            begin
                                hres_next = 40'({xd_reg, 16'h0});
                                vres_next = 40'({word, 16'h0});
                            end
                            2'd2:
                            begin
                                hres_next = 40'(34'(xd_reg) * 34'(CM_TO_DPI));
                                vres_next = 40'(34'(word) * 34'(CM_TO_DPI));
                            end
                            default: ;
                        endcase
                    end
                    4'd7: thumb_next = b;
                    default:
                    begin
                        if (thumb_bytes == {2'b00, seg_dec})
                        begin
                            phase_next = (seg_dec != 16'd0) ? PH_SKIP : PH_HUNT;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                endcase
                if (emit)
                begin
                    perr_next = E_JFIF;
                    emit_code = E_JFIF;
                end
            end
            PH_SOS:
            begin
                if (fpos_reg < 4'd2)
                begin
                    fpos_next = fpos_reg + 4'd1;
                end
                else
                begin
                    selv_next = 3'b000;
                    serr_next = 1'b0;
                    fpos_next = 4'd0;
                    if (b == 8'd0)
                    begin
                        phase_next = PH_SOST;
                    end
                    else
                    begin
                        seg_next   = {7'd0, b, 1'b0};
                        phase_next = PH_SOSC;
                    end
                end
            end
            PH_SOSC:
            begin
                if (!fpos_reg[0])
                begin
                    slot_next = 2'd3;
                    if (!serr_reg)
                    begin
                        for (int i = 2; i >= 0; i--)
                        begin
                            if (2'(i) < fcomp_reg && ids_reg[i] == b)
                            begin
                                slot_next = 2'(i);
                            end
                        end
                        if (slot_next == 2'd3)
                        begin
                            serr_next = 1'b1;
                            perr_next = E_SCANID;
                        end
                    end
                end
                else if (!serr_reg && slot_reg != 2'd3)
                begin
                    sel_next[slot_reg]  = b;
                    selv_next[slot_reg] = 1'b1;
                end
                fpos_next = {fpos_reg[3:1], !fpos_reg[0]};
                seg_next  = seg_dec;
                if (seg_dec == 16'd0)
                begin
                    fpos_next  = 4'd0;
                    phase_next = PH_SOST;
                end
            end
            PH_SOST:
            begin
                if (fpos_reg >= 4'd2)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (selv_reg[i])
                        begin
                            if (!(sel_reg[i][3:0] == 4'd0 || sel_reg[i][3:0] == 4'd1
                                  || sel_reg[i][3:0] == 4'd15))
                            begin
                                ac_bad = 1'b1;
                            end
                            if (!(sel_reg[i][7:4] == 4'd0 || sel_reg[i][7:4] == 4'd1
                                  || sel_reg[i][7:4] == 4'd15))
                            begin
                                dc_bad = 1'b1;
                            end
                        end
                    end
                    if (ac_bad)
                    begin
                        perr_next = E_AC;
                    end
                    if (dc_bad)
                    begin
                        perr_next = E_DC;
                    end
                    emit      = 1'b1;
                    emit_ok   = (perr_next == E_NONE);
                    emit_code = perr_next;
                end
                else
                begin
                    fpos_next = fpos_reg + 4'd1;
                end
            end
            default: ;
        endcase

        if (emit)
        begin
            phase_next = PH_DONE;
        end

        if (entry.end_of_stream && !emit && phase_reg != PH_DONE)
        begin
            emit      = 1'b1;
            emit_ok   = 1'b0;
            emit_code = E_NOSOS;
        end

        off_wide = OFFSET_BITS_MAX'(offset_next);
        odata_next.header_ok        = emit_ok;
        odata_next.error_code       = emit_code;
        odata_next.image_width      = fw_next;
        odata_next.image_height     = fh_next;
        odata_next.component_count  = fcomp_next;
        odata_next.hres_fixed       = hres_next;
        odata_next.vres_fixed       = vres_next;
        odata_next.scan_data_offset = emit_ok ? off_wide[31:0] : 32'd0;

        if (entry.end_of_stream)
        begin
            phase_next  = PH_HUNT;
            seg_next    = 16'd0;
            fpos_next   = 4'd0;
            fw_next     = 16'd0;
            fh_next     = 16'd0;
            ids_next[0] = 8'd0;
            ids_next[1] = 8'd0;
            ids_next[2] = 8'd0;
            fcomp_next  = 2'd0;
            hres_next   = DPI_DEFAULT;
            vres_next   = DPI_DEFAULT;
            units_next  = 2'd0;
            perr_next   = E_NONE;
            offset_next = '0;
            app0_next   = 1'b0;
            hold_next   = 8'd0;
            xd_next     = 16'd0;
            thumb_next  = 8'd0;
            tag_next    = 1'b0;
            sel_next[0] = 8'd0;
            sel_next[1] = 8'd0;
            sel_next[2] = 8'd0;
            selv_next   = 3'b000;
            slot_next   = 2'd3;
            serr_next   = 1'b0;
        end

        ovalid_next = ovalid_reg && !out_ready;
        if (pop && emit)
        begin
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            seg_reg    <= 16'd0;
            fpos_reg   <= 4'd0;
            fw_reg     <= 16'd0;
            fh_reg     <= 16'd0;
            ids_reg[0] <= 8'd0;
            ids_reg[1] <= 8'd0;
            ids_reg[2] <= 8'd0;
            fcomp_reg  <= 2'd0;
            hres_reg   <= DPI_DEFAULT;
            vres_reg   <= DPI_DEFAULT;
            units_reg  <= 2'd0;
            perr_reg   <= E_NONE;
            offset_reg <= '0;
            app0_reg   <= 1'b0;
            hold_reg   <= 8'd0;
            xd_reg     <= 16'd0;
            thumb_reg  <= 8'd0;
            tag_reg    <= 1'b0;
            sel_reg[0] <= 8'd0;
            sel_reg[1] <= 8'd0;
            sel_reg[2] <= 8'd0;
            selv_reg   <= 3'b000;
            slot_reg   <= 2'd3;
            serr_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            if (pop)
            begin
                phase_reg  <= phase_next;
                seg_reg    <= seg_next;
                fpos_reg   <= fpos_next;
                fw_reg     <= fw_next;
                fh_reg     <= fh_next;
                ids_reg    <= ids_next;
                fcomp_reg  <= fcomp_next;
                hres_reg   <= hres_next;
                vres_reg   <= vres_next;
                units_reg  <= units_next;
                perr_reg   <= perr_next;
                offset_reg <= offset_next;
                app0_reg   <= app0_next;
                hold_reg   <= hold_next;
                xd_reg     <= xd_next;
                thumb_reg  <= thumb_next;
                tag_reg    <= tag_next;
                sel_reg    <= sel_next;
                selv_reg   <= selv_next;
                slot_reg   <= slot_next;
                serr_reg   <= serr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            odata_reg <= odata_next;
        end
    end

endmodule

>>> rtl/core/jpeg_header_marker_parser.sv
// Top level of the JPEG header marker parser.
// Depends on jhmp_pkg, jhmp_front, jhmp_fifo and jhmp_back.
//
// Usage: the file is streamed in one byte per transaction on the in channel,
// with end_of_stream set on the last byte. The parser hunts for markers,
// skips segments by length, reads SOF0 and the JFIF density, and checks the
// SOS table selectors. One result transaction leaves on the out channel at
// the end of the SOS header, on a fatal JFIF fault, or at end of stream when
// no result was sent for that file; later bytes of the file are dropped.
// The cfg channel writes the strict_version bit and is always ready.
// Throughput is one byte per cycle while no result waits on a stalled
// receiver, set by the byte-wide state machine in the back end. The deciding
// byte is written into the two-entry queue, and the back end registers the
// result when it pops that byte, after any bytes queued ahead of it. When the
// receiver stalls, the back end holds a pending result and the queue absorbs
// two more bytes before in_ready drops.
// Reset clears the parse state, the queue and strict_version; the block is
// ready as soon as reset is released.
module jpeg_header_marker_parser #(
    parameter int OFFSET_BITS = jhmp_pkg::OFFSET_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  jhmp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output jhmp_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import jhmp_pkg::*;

    logic        strict_reg;
    logic        push;
    logic        pop;
    jhmp_entry_t wr_entry;
    jhmp_entry_t rd_entry;
    jhmp_qstat_t qstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            strict_reg <= cfg_data;
        end
    end

    jhmp_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .qstat    (qstat),
        .push     (push),
        .entry    (wr_entry)
    );

    jhmp_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_entry),
        .pop     (pop),
        .rd_data (rd_entry),
        .qstat   (qstat)
    );

    jhmp_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .strict_version (strict_reg),
        .qstat          (qstat),
        .entry          (rd_entry),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data)
    );

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !qstat.empty)
        else $error("Queue empty after a write.");

    a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!out_valid || out_ready))
        else $error("Byte consumed while a result was blocked.");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("Read from an empty queue.");

endmodule

>>> tb/sv/jpeg_header_marker_parser_test.sv
// Self-checking testbench for the JPEG header marker parser.
// Streams directed and random JPEG byte files and compares every result against a
// built-in header predictor; depends on jhmp_pkg and jpeg_header_marker_parser.
module jpeg_header_marker_parser_test;
    timeunit 1ns;
    timeprecision 1ps;
    import jhmp_pkg::*;

    localparam logic [4:0] PH_HUNT = 5'd0, PH_PREFIX = 5'd1, PH_LEN = 5'd2,
        PH_SKIP = 5'd3, PH_SOF = 5'd4, PH_SOFC = 5'd5, PH_APPID = 5'd6,
        PH_JFIF = 5'd7, PH_SOS = 5'd8, PH_SOSC = 5'd9, PH_SOST = 5'd10,
        PH_DONE = 5'd11;
    localparam logic [3:0] E_OK = 4'd0, E_PREC = 4'd1, E_COMP = 4'd2, E_SOFN = 4'd3,
        E_RSVD = 4'd4, E_SCANID = 4'd5, E_AC = 4'd6, E_DC = 4'd7, E_JFIF = 4'd8,
        E_NOSOS = 4'd9;
    localparam logic [39:0] DPI_DEFAULT = 40'd72 << 16;
    localparam logic [39:0] CM_TO_DPI = 40'h28a3d;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;

    jpeg_header_marker_parser i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #200ms;
        $display("jpeg_header_marker_parser verification failed");
        $finish;
    end

    // Predictor state.
    logic        strict_mode;
    logic [4:0]  phase;
    logic [15:0] seg_left;
    logic [3:0]  fpos;
    logic [15:0] fr_w, fr_h;
    logic [7:0]  comp_id [3];
    logic [1:0]  fr_comps;
    logic [39:0] hres, vres;
    logic [1:0]  units;
    logic [3:0]  err_latched;
    logic [31:0] offset;
    logic [7:0]  marker, hi_byte, thumb_w;
    logic [15:0] xdens;
    logic        tag_ok;
    logic [7:0]  selector [3];
    logic        sel_seen [3];
    logic [1:0]  slot;
    logic        id_miss;

    out_item_t expected_q [$];
    int errors = 0;
    int results_seen = 0;
    int bytes_sent = 0;
    int files_sent = 0;
    int send_idle = 0;
    int recv_idle = 0;
    logic [7:0] file_buf [$];

    function automatic void clear_parse();
        phase = PH_HUNT; seg_left = 0; fpos = 0; fr_w = 0; fr_h = 0;
        for (int i = 0; i < 3; i++)
        begin
            comp_id[i] = 0; selector[i] = 0; sel_seen[i] = 0;
        end
        fr_comps = 0; hres = DPI_DEFAULT; vres = DPI_DEFAULT; units = 0;
        err_latched = E_OK; offset = 0; marker = 0; hi_byte = 0; xdens = 0;
        thumb_w = 0; tag_ok = 0; slot = 3; id_miss = 0;
    endfunction

    function automatic void push_result(logic ok, logic [3:0] code);
        out_item_t r;
        r.header_ok = ok;
        r.error_code = code;
        r.image_width = fr_w;
        r.image_height = fr_h;
        r.component_count = fr_comps;
        r.hres_fixed = hres;
        r.vres_fixed = vres;
        r.scan_data_offset = ok ? offset : 32'd0;
        expected_q.push_back(r);
        phase = PH_DONE;
    endfunction

    function automatic logic nib_ok(logic [3:0] n);
        return n == 4'd0 || n == 4'd1 || n == 4'd15;
    endfunction

    function automatic void take_marker(logic [7:0] c);
        marker = c;
        fpos = 0;
        if (c == 8'h00 || c == 8'h01 || (c >= 8'hD0 && c <= 8'hD9))
            phase = PH_HUNT;
        else if (c == 8'hC0)
            phase = PH_SOF;
        else if (c == 8'hDA)
            phase = PH_SOS;
        else if (c == 8'hDC || c == 8'hDD)
        begin
            seg_left = 4; phase = PH_SKIP;
        end
        else if (c == 8'hC4 || c == 8'hDB || c >= 8'hE0)
            phase = PH_LEN;
        else if ((c >= 8'hC1 && c <= 8'hCF) || c == 8'hDE || c == 8'hDF)
        begin
            err_latched = E_SOFN; phase = PH_LEN;
        end
        else
        begin
            err_latched = E_RSVD; phase = PH_LEN;
        end
    endfunction

    function automatic logic jfif_step(logic [7:0] b);
        logic [15:0] v;
        logic [15:0] y;
        seg_left--;
        case (fpos)
            4'd0, 4'd3, 4'd5: hi_byte = b;
            4'd1:
            begin
                v = {hi_byte, b};
                if (strict_mode ? (v != 16'h100 && v != 16'h101) : (v < 16'h100))
                begin
                    err_latched = E_JFIF; push_result(0, E_JFIF); return 1;
                end
            end
            4'd2: units = (b > 8'd2) ? 2'd3 : b[1:0];
            4'd4: xdens = {hi_byte, b};
            4'd6:
            begin
                y = {hi_byte, b};
                if (units == 2'd0)
                begin
                    hres = DPI_DEFAULT * 40'(xdens); vres = DPI_DEFAULT * 40'(y);
                end
                else if (units == 2'd1)
                begin
                    hres = 40'(xdens) << 16; vres = 40'(y) << 16;
                end
                else if (units == 2'd2)
                begin
                    hres = CM_TO_DPI * 40'(xdens); vres = CM_TO_DPI * 40'(y);
                end
            end
            4'd7: thumb_w = b;
            default:
            begin
                if (32'd3 * 32'(thumb_w) * 32'(b) == 32'(seg_left))
                begin
                    phase = (seg_left != 0) ? PH_SKIP : PH_HUNT;
                    return 0;
                end
                err_latched = E_JFIF; push_result(0, E_JFIF); return 1;
            end
        endcase
        fpos++;
        if (seg_left == 0)
        begin
            err_latched = E_JFIF; push_result(0, E_JFIF); return 1;
        end
        return 0;
    endfunction

    function automatic logic parse_byte(logic [7:0] b);
        logic [15:0] len;
        logic bad_ac, bad_dc;
        case (phase)
            PH_HUNT: if (b == 8'hFF) phase = PH_PREFIX;
            PH_PREFIX: if (b != 8'hFF) take_marker(b);
            PH_LEN:
                if (fpos == 0)
                begin
                    hi_byte = b; fpos = 1;
                end
                else
                begin
                    len = {hi_byte, b};
                    seg_left = (len >= 2) ? len - 16'd2 : 16'd0;
                    fpos = 0;
                    if (marker == 8'hE0 && seg_left > 5)
                    begin
                        tag_ok = 1; phase = PH_APPID;
                    end
                    else
                        phase = (seg_left != 0) ? PH_SKIP : PH_HUNT;
                end
            PH_SKIP:
            begin
                if (seg_left != 0) seg_left--;
                if (seg_left == 0) phase = PH_HUNT;
            end
            PH_SOF:
            begin
                case (fpos)
                    4'd2: if (b != 8'd8) err_latched = E_PREC;
                    4'd3, 4'd5: hi_byte = b;
                    4'd4: fr_h = {hi_byte, b};
                    4'd6: fr_w = {hi_byte, b};
                    4'd7:
                    begin
                        fpos = 0;
                        if (b == 8'd1 || b == 8'd3)
                        begin
                            fr_comps = b[1:0]; seg_left = 16'd3 * 16'(b); phase = PH_SOFC;
                        end
                        else
                        begin
                            fr_comps = 0; err_latched = E_COMP; phase = PH_HUNT;
                        end
                        return 0;
                    end
                    default: ;
                endcase
                fpos++;
            end
            PH_SOFC:
            begin
                if (fpos % 3 == 0 && fpos / 3 < 3) comp_id[fpos / 3] = b;
                fpos++;
                seg_left--;
                if (seg_left == 0) phase = PH_HUNT;
            end
            PH_APPID:
            begin
                seg_left--;
                if (fpos < 4 && b != 8'("JFIF" >> (8 * (3 - fpos)))) tag_ok = 0;
                fpos++;
                if (fpos == 5)
                begin
                    fpos = 0;
                    if (tag_ok) phase = PH_JFIF;
                    else phase = (seg_left != 0) ? PH_SKIP : PH_HUNT;
                end
            end
            PH_JFIF: return jfif_step(b);
            PH_SOS:
                if (fpos < 2)
                    fpos++;
                else
                begin
                    for (int i = 0; i < 3; i++) sel_seen[i] = 0;
                    id_miss = 0; fpos = 0;
                    if (b == 0) phase = PH_SOST;
                    else
                    begin
                        seg_left = 16'd2 * 16'(b); phase = PH_SOSC;
                    end
                end
            PH_SOSC:
            begin
                if (fpos[0] == 1'b0)
                begin
                    slot = 3;
                    if (!id_miss)
                    begin
                        for (int i = 2; i >= 0; i--)
                            if (i < fr_comps && comp_id[i] == b) slot = 2'(i);
                        if (slot == 3)
                        begin
                            id_miss = 1; err_latched = E_SCANID;
                        end
                    end
                end
                else if (!id_miss && slot < 3)
                begin
                    selector[slot] = b; sel_seen[slot] = 1;
                end
                fpos[0] = ~fpos[0];
                seg_left--;
                if (seg_left == 0)
                begin
                    fpos = 0; phase = PH_SOST;
                end
            end
            PH_SOST:
            begin
                if (fpos >= 2)
                begin
                    bad_ac = 0; bad_dc = 0;
                    for (int i = 0; i < 3; i++)
                        if (sel_seen[i])
                        begin
                            if (!nib_ok(selector[i][3:0])) bad_ac = 1;
                            if (!nib_ok(selector[i][7:4])) bad_dc = 1;
                        end
                    if (bad_ac) err_latched = E_AC;
                    if (bad_dc) err_latched = E_DC;
                    push_result(err_latched == E_OK, err_latched);
                    return 1;
                end
                fpos++;
            end
            default: ;
        endcase
        return 0;
    endfunction

    function automatic void predict_byte(in_item_t it);
        logic got;
        got = 0;
        if (phase != PH_DONE)
        begin
            offset++;
            got = parse_byte(it.data_byte);
        end
        if (it.end_of_stream)
        begin
            if (!got && phase != PH_DONE) push_result(0, E_NOSOS);
            clear_parse();
        end
    endfunction

    // Receiver and checker.
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (out_data.header_ok !== e.header_ok)
                begin
                    $error("header_ok exp %0d got %0d", e.header_ok, out_data.header_ok); errors++;
                end
                if (out_data.error_code !== e.error_code)
                begin
                    $error("error_code exp %0d got %0d", e.error_code, out_data.error_code); errors++;
                end
                if (out_data.image_width !== e.image_width)
                begin
                    $error("image_width exp %0d got %0d", e.image_width, out_data.image_width);
                    errors++;
                end
                if (out_data.image_height !== e.image_height)
                begin
                    $error("image_height exp %0d got %0d", e.image_height, out_data.image_height);
                    errors++;
                end
                if (out_data.component_count !== e.component_count)
                begin
                    $error("component_count exp %0d got %0d", e.component_count,
                        out_data.component_count);
                    errors++;
                end
                if (out_data.hres_fixed !== e.hres_fixed)
                begin
                    $error("hres_fixed exp %h got %h", e.hres_fixed, out_data.hres_fixed); errors++;
                end
                if (out_data.vres_fixed !== e.vres_fixed)
                begin
                    $error("vres_fixed exp %h got %h", e.vres_fixed, out_data.vres_fixed); errors++;
                end
                if (out_data.scan_data_offset !== e.scan_data_offset)
                begin
                    $error("scan_data_offset exp %0d got %0d", e.scan_data_offset,
                        out_data.scan_data_offset);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    task automatic send_byte(logic [7:0] b, logic eos);
        in_item_t it;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        it.data_byte = b;
        it.end_of_stream = eos;
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_byte(it);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_buf.size(); i++)
            send_byte(file_buf[i], i == file_buf.size() - 1);
        files_sent++;
        file_buf.delete();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_strict(logic v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        strict_mode = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add(logic [7:0] b);
        file_buf.push_back(b);
    endfunction

    function automatic void add16(int v);
        add(v[15:8]); add(v[7:0]);
    endfunction

    function automatic logic [7:0] pick_sel();
        case ($urandom_range(4))
            0: return 8'h00;
            1: return 8'h11;
            2: return 8'hF1;
            3: return 8'h10;
            default: return 8'($urandom);
        endcase
    endfunction

    // Builds a plausible file with random content and occasional faults.
    function automatic void build_file(int sz_big);
        int ncomp, nscan, tw, th, sz;
        logic [7:0] ids [3];
        add(8'hFF); add(8'hD8);
        if ($urandom_range(3) != 0)
        begin
            tw = $urandom_range(2); th = $urandom_range(2);
            sz = 16 + 3 * tw * th + (($urandom_range(9) == 0) ? 1 : 0);
            add(8'hFF); add(8'hE0); add16(sz);
            add("J"); add(($urandom_range(15) == 0) ? 8'($urandom) : "F");
            add("I"); add("F"); add(8'($urandom));
            add(($urandom_range(7) == 0) ? 8'($urandom) : 8'h01);
            add(8'($urandom_range(3)));
            add(8'($urandom_range(2))); add(8'($urandom));
            add16($urandom); add16($urandom);
            add(8'(tw)); add(8'(th));
            for (int i = 0; i < sz - 16; i++) add(8'($urandom));
        end
        if ($urandom_range(2) == 0)
        begin
            sz = $urandom_range(2, sz_big ? 300 : 12);
            add(8'hFF); add(($urandom_range(1)) ? 8'hDB : 8'hC4); add16(sz);
            for (int i = 0; i < sz - 2; i++) add(8'($urandom));
        end
        if ($urandom_range(9) == 0)
        begin
            add(8'hFF); add(8'($urandom)); add16($urandom_range(4));
            add(8'($urandom)); add(8'($urandom));
        end
        ncomp = ($urandom_range(9) == 0) ? $urandom_range(255) : (($urandom_range(1)) ? 3 : 1);
        add(8'hFF); add(8'hC0); add16(8 + 3 * ncomp);
        add(($urandom_range(9) == 0) ? 8'($urandom) : 8'd8);
        add16($urandom); add16($urandom); add(8'(ncomp));
        for (int i = 0; i < 3; i++) ids[i] = 8'($urandom_range(1, 4) + i * 4);
        if (ncomp == 1 || ncomp == 3)
            for (int i = 0; i < ncomp; i++)
            begin
                add(ids[i]); add(8'h11); add(8'($urandom_range(1)));
            end
        if ($urandom_range(19) == 0) add(8'hFF);
        add(8'hFF); add(8'hDA);
        nscan = ($urandom_range(15) == 0) ? $urandom_range(0, 4) : ncomp % 4;
        add16(6 + 2 * nscan); add(8'(nscan));
        for (int i = 0; i < nscan; i++)
        begin
            add(($urandom_range(15) == 0) ? 8'($urandom) : ids[i % 3]); add(pick_sel());
        end
        add(8'h00); add(8'h3F); add(8'h00);
        for (int i = $urandom_range(5); i > 0; i--) add(8'($urandom));
        if ($urandom_range(9) == 0) file_buf = file_buf[0:$urandom_range(file_buf.size() - 1)];
    endfunction

    typedef struct {
        logic [7:0] b;
        logic       eos;
        logic       chk;
        logic [3:0] code;
    } row_t;

    initial
    begin
        row_t rows [$];
        int mode;
        strict_mode = 0;
        clear_parse();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: one-byte files, reserved marker, other SOF, and a JFIF segment
        // with a version below one.
        rows = '{
            '{8'h00, 1, 1, E_NOSOS}, '{8'hFF, 1, 1, E_NOSOS},
            '{8'hFF, 0, 0, E_OK}, '{8'h02, 0, 0, E_OK}, '{8'h00, 0, 0, E_OK},
            '{8'h00, 1, 1, E_NOSOS},
            '{8'hFF, 0, 0, E_OK}, '{8'hC1, 0, 0, E_OK}, '{8'h00, 1, 1, E_NOSOS},
            '{8'hFF, 0, 0, E_OK}, '{8'hE0, 0, 0, E_OK}, '{8'h00, 0, 0, E_OK},
            '{8'h10, 0, 0, E_OK}, '{"J", 0, 0, E_OK}, '{"F", 0, 0, E_OK},
            '{"I", 0, 0, E_OK}, '{"F", 0, 0, E_OK}, '{8'h00, 0, 0, E_OK},
            '{8'h00, 0, 0, E_OK}, '{8'hFF, 0, 1, E_JFIF}, '{8'hFF, 1, 0, E_OK}
        };
        foreach (rows[i])
        begin
            send_byte(rows[i].b, rows[i].eos);
            if (rows[i].chk && (expected_q.size() == 0 ||
                expected_q[$].error_code != rows[i].code))
            begin
                $error("directed row %0d error_code exp %0d", i, rows[i].code);
                errors++;
            end
        end
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 30 : (ph == 1) ? 59 : 0;
            recv_idle = (ph == 0) ? 59 : (ph == 1) ? 30 : 0;
            write_strict(ph == 1);
            mode = 0;
            while (bytes_sent < 700 * (ph + 1))
            begin
                build_file(($urandom_range(19) == 0) ? 1 : 0);
                if ($urandom_range(11) == 0)
                    for (int i = 0; i < 4; i++)
                        file_buf[$urandom_range(file_buf.size() - 1)] = 8'($urandom);
                send_file();
                if (mode++ == 7) drain();
            end
            drain();
        end
        write_strict(1'b0);

        drain();
        $display("Sent %0d bytes in %0d files; %0d header results checked.",
            bytes_sent, files_sent, results_seen);
        if (errors == 0)
            $display("jpeg_header_marker_parser verification clean");
        else
            $display("jpeg_header_marker_parser verification failed");
        $finish;
    end
endmodule
